### rtl/core/dteq_pkg.sv
package dteq_pkg;

  localparam int unsigned TableDepth   = 32;
  localparam int unsigned TimeBits     = 32;
  localparam int unsigned ResetPollMs  = 100;
  localparam int unsigned CfgAddrBits  = 3;
  localparam int unsigned QueueDepth   = 2;

  localparam logic [CfgAddrBits-1:0] AddrPollPeriod = 3'd0;

  typedef enum logic [1:0] {
    KindFired   = 2'd0,
    KindQueued  = 2'd1,
    KindDropped = 2'd2,
    KindNone    = 2'd3
  } kind_e;

  typedef enum logic {
    ActSchedule = 1'b0,
    ActTick     = 1'b1
  } action_e;

  typedef struct packed {
    logic        action;
    logic [15:0] event_tag;
    logic [15:0] delay_ms;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] fired_tag;
    logic        last_of_run;
  } out_req_t;

  // classified command handed from front to back
  typedef struct packed {
    logic        immediate;
    logic        tick;
    logic [15:0] tag;
    logic [15:0] delay;
  } cmd_t;

endpackage

### rtl/core/deadline_timer_event_queue_top.sv
// Deadline timer event queue.
// Input channel in_valid_i/in_stall_o/in_req_i: schedule (action 0) or tick
// (action 1). Output channel out_valid_o/out_stall_i/out_req_o: results.
// An APB port sets poll_period_ms at address 0 (reset 100).
// A request passes a two-entry command queue into the execution engine.
// Schedule with delay 0: one fired result, with no slot search.
// Schedule with delay: slot search from slot 0 for the lowest free slot.
// Tick: each fired event costs one full table scan, plus a final scan.
// The scan loop over the table sets the throughput.
// Every request yields at least one result; the final one has last_of_run.
// Reset clears the clock, the arrival stamp and all slot valid bits.
// When the receiver stalls, the result register holds; the engine waits only
// to hand over a result. The command queue takes requests until it is full.
module deadline_timer_event_queue_top #(
  parameter int unsigned TableDepth = dteq_pkg::TableDepth,
  parameter int unsigned TimeBits   = dteq_pkg::TimeBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  dteq_pkg::in_req_t                   in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output dteq_pkg::out_req_t                  out_req_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dteq_pkg::CfgAddrBits-1:0]    paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic [15:0]    poll_q;
  logic           cmd_valid, cmd_pop;
  dteq_pkg::cmd_t cmd;

  assign pready = 1'b1;
  assign prdata = (paddr == dteq_pkg::AddrPollPeriod) ? {16'd0, poll_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_q <= 16'(dteq_pkg::ResetPollMs);
    end else if (psel && penable && pwrite && paddr == dteq_pkg::AddrPollPeriod) begin
      poll_q <= pwdata[15:0];
    end
  end

  dteq_front #(.QDepth(dteq_pkg::QueueDepth)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_req_i,
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd)
  );

  dteq_back #(.Depth(TableDepth), .TBits(TimeBits)) u_back (
    .clk_i, .rst_ni,
    .poll_period_i(poll_q),
    .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .out_valid_o, .out_stall_i, .out_req_o
  );

endmodule

### rtl/core/dteq_front.sv
module dteq_front #(
  parameter int unsigned QDepth = dteq_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dteq_pkg::in_req_t in_req_i,
  output logic              cmd_valid_o,
  input  logic              cmd_pop_i,
  output dteq_pkg::cmd_t    cmd_o
);

  localparam int unsigned PtrBits = (QDepth > 1) ? $clog2(QDepth) : 1;

  dteq_pkg::cmd_t      mem_q [QDepth];
  logic [PtrBits-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PtrBits:0]    cnt_q, cnt_d;
  logic                push;
  dteq_pkg::cmd_t      cmd_in;

  always_comb begin
    cmd_in.tick      = (in_req_i.action == dteq_pkg::ActTick);
    cmd_in.immediate = !cmd_in.tick && (in_req_i.delay_ms == 16'd0);
    cmd_in.tag       = in_req_i.event_tag;
    cmd_in.delay     = in_req_i.delay_ms;
  end

  assign in_stall_o  = (cnt_q == (PtrBits+1)'(QDepth));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrBits'(QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (cmd_pop_i) begin
      rd_d = (rd_q == PtrBits'(QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    cnt_d = cnt_q + (PtrBits+1)'(push) - (PtrBits+1)'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cmd_in;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cmd_valid_o) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrBits+1)'(QDepth)) else $error("queue overflow");
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !cmd_pop_i) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
`endif

endmodule

### rtl/core/dteq_back.sv
module dteq_back #(
  parameter int unsigned Depth = dteq_pkg::TableDepth,
  parameter int unsigned TBits = dteq_pkg::TimeBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        poll_period_i,
  input  logic               cmd_valid_i,
  output logic               cmd_pop_o,
  input  dteq_pkg::cmd_t     cmd_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dteq_pkg::out_req_t out_req_o
);

  localparam int unsigned IdxBits = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StFind  = 5'b00010,
    StScan  = 5'b00100,
    StFire  = 5'b01000,
    StEmit  = 5'b10000
  } state_e;

  state_e              st_q, st_d;
  logic [TBits-1:0]    clock_q, clock_d;
  logic [15:0]         arr_q, arr_d;
  logic [Depth-1:0]    valid_q, valid_d;
  logic [TBits-1:0]    dl_mem [Depth];
  logic [15:0]         tag_mem [Depth];
  logic [15:0]         ord_mem [Depth];
  logic [IdxBits:0]    idx_q, idx_d;
  logic                found_q, found_d, any_q, any_d;
  logic [IdxBits-1:0]  best_q, best_d;
  logic [TBits-1:0]    bage_q, bage_d;
  logic [15:0]         bord_q, bord_d;
  dteq_pkg::cmd_t      cmd_q, cmd_d;
  logic                ov_q, ov_d;
  dteq_pkg::out_req_t  out_q, out_d;
  dteq_pkg::out_req_t  pend_q, pend_d;
  logic                wr_en;
  logic [IdxBits-1:0]  wr_idx;
  logic [IdxBits-1:0]  ci;
  logic [TBits-1:0]    age;
  logic [15:0]         od;
  logic                earlier, due;
  logic                out_free;

  assign out_valid_o = ov_q;
  assign out_req_o   = out_q;
  assign out_free    = !ov_q || !out_stall_i;
  assign ci          = idx_q[IdxBits-1:0];
  assign age         = clock_q - dl_mem[ci];
  assign od          = bord_q - ord_mem[ci];
  assign earlier     = (od != 16'd0) && !od[15];
  assign due         = valid_q[ci] && !age[TBits-1];

  always_comb begin
    st_d    = st_q;
    clock_d = clock_q;
    arr_d   = arr_q;
    valid_d = valid_q;
    idx_d   = idx_q;
    found_d = found_q;
    any_d   = any_q;
    best_d  = best_q;
    bage_d  = bage_q;
    bord_d  = bord_q;
    cmd_d   = cmd_q;
    ov_d    = ov_q && out_stall_i;
    out_d   = out_q;
    pend_d  = pend_q;
    cmd_pop_o = 1'b0;
    wr_en   = 1'b0;
    wr_idx  = ci;
    unique case (st_q)
      StIdle: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          idx_d     = '0;
          any_d     = 1'b0;
          found_d   = 1'b0;
          if (cmd_i.tick) begin
            clock_d = clock_q + TBits'(poll_period_i);
            st_d    = StScan;
          end else if (cmd_i.immediate) begin
            pend_d = '{dteq_pkg::KindFired, cmd_i.tag, 1'b1};
            st_d   = StEmit;
          end else begin
            st_d = StFind;
          end
        end
      end
      StFind: begin
        // lowest free slot, one per cycle
        if (!valid_q[ci]) begin
          wr_en       = 1'b1;
          valid_d[ci] = 1'b1;
          arr_d       = arr_q + 16'd1;
          pend_d = '{dteq_pkg::KindQueued, cmd_q.tag, 1'b1};
          st_d   = StEmit;
        end else if (idx_q == (IdxBits+1)'(Depth - 1)) begin
          pend_d = '{dteq_pkg::KindDropped, cmd_q.tag, 1'b1};
          st_d   = StEmit;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StScan: begin
        if (due && (!found_q || age > bage_q || (age == bage_q && earlier))) begin
          found_d = 1'b1;
          best_d  = ci;
          bage_d  = age;
          bord_d  = ord_mem[ci];
        end
        if (idx_q == (IdxBits+1)'(Depth - 1)) begin
          st_d = StFire;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StFire: begin
        // pend_q holds previous fired entry until the next pick decides last
        if (out_free || !any_q) begin
          if (found_q) begin
            if (any_q) begin
              out_d = pend_q;
              ov_d  = 1'b1;
            end
            valid_d[best_q] = 1'b0;
            pend_d  = '{dteq_pkg::KindFired, tag_mem[best_q], 1'b0};
            any_d   = 1'b1;
            found_d = 1'b0;
            idx_d   = '0;
            st_d    = StScan;
          end else if (any_q) begin
            pend_d.last_of_run = 1'b1;
            st_d = StEmit;
          end else begin
            pend_d = '{dteq_pkg::KindNone, 16'd0, 1'b1};
            st_d   = StEmit;
          end
        end
      end
      StEmit: begin
        if (out_free) begin
          out_d = pend_q;
          ov_d  = 1'b1;
          st_d  = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      clock_q <= '0;
      arr_q   <= '0;
      valid_q <= '0;
      ov_q    <= 1'b0;
      idx_q   <= '0;
      found_q <= 1'b0;
      any_q   <= 1'b0;
    end else begin
      st_q    <= st_d;
      clock_q <= clock_d;
      arr_q   <= arr_d;
      valid_q <= valid_d;
      ov_q    <= ov_d;
      idx_q   <= idx_d;
      found_q <= found_d;
      any_q   <= any_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    bage_q <= bage_d;
    bord_q <= bord_d;
    cmd_q  <= cmd_d;
    out_q  <= out_d;
    pend_q <= pend_d;
    if (wr_en) begin
      dl_mem[wr_idx]  <= clock_q + TBits'(cmd_q.delay);
      tag_mem[wr_idx] <= cmd_q.tag;
      ord_mem[wr_idx] <= arr_q;
    end
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(st_q)) else $error("state not one-hot");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> ov_q && $stable(out_q)) else $error("result lost");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> st_q == StIdle) else $error("pop while busy");
`endif

endmodule
